// ===== hdl/svd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svd_pkg
// Shared types, constants and CORDIC helpers for the 2x2 closed-form SVD unit.
// ----------------------------------------------------------------------------
package svd_pkg;

    localparam int CordicStagesDef = 16;
    localparam int AtanTabLen      = 24;
    localparam int W               = 34;   // CORDIC datapath and angle width

    // binary angles: pi = 2^31
    localparam logic signed [W-1:0] AngPi     = 34'sh080000000;
    localparam logic signed [W-1:0] AngHalfPi = 34'sh040000000;
    localparam logic [29:0]         GainQ30   = 30'h26DD3B6A;
    localparam logic signed [W-1:0] GainInit  = 34'sh026DD3B6A;

    typedef struct packed {
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic signed [W-1:0] z;
        logic                zero;
    } t_vec;

    typedef struct packed {
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic signed [W-1:0] z;
        logic                neg;
    } t_rot;

    function automatic logic signed [W-1:0] atan_at(input int i);
        logic signed [W-1:0] a;
        unique case (i)
            0:  a = 34'sh020000000;
            1:  a = 34'sh012E4051E;
            2:  a = 34'sh009FB385B;
            3:  a = 34'sh0051111D4;
            4:  a = 34'sh0028B0D43;
            5:  a = 34'sh00145D7E1;
            6:  a = 34'sh000A2F61E;
            7:  a = 34'sh000517C55;
            8:  a = 34'sh00028BE53;
            9:  a = 34'sh000145F2F;
            10: a = 34'sh0000A2F98;
            11: a = 34'sh0000517CC;
            12: a = 34'sh000028BE6;
            13: a = 34'sh0000145F3;
            14: a = 34'sh00000A2F9;
            15: a = 34'sh00000517C;
            16: a = 34'sh0000028BE;
            17: a = 34'sh00000145F;
            18: a = 34'sh000000A2F;
            19: a = 34'sh000000517;
            20: a = 34'sh00000028B;
            21: a = 34'sh000000145;
            22: a = 34'sh0000000A2;
            23: a = 34'sh000000051;
            default: a = '0;
        endcase
        return a;
    endfunction

    // vectoring start: scale by 2^14, fold the left half plane onto the right
    function automatic t_vec vinit(input logic signed [16:0] a, input logic signed [16:0] b);
        t_vec v;
        v.x    = W'(a) <<< 14;
        v.y    = W'(b) <<< 14;
        v.z    = '0;
        v.zero = (a == '0) && (b == '0);
        if (a[16]) begin
            v.z = b[16] ? -AngPi : AngPi;
            v.x = -v.x;
            v.y = -v.y;
        end
        return v;
    endfunction

    function automatic t_vec vstep(input t_vec v, input int i);
        t_vec o;
        logic signed [W-1:0] dx;
        logic signed [W-1:0] dy;
        logic signed [W-1:0] at;
        dx = v.y >>> i;
        dy = v.x >>> i;
        at = atan_at(i);
        o  = v;
        if (!v.y[W-1]) begin
            o.x = v.x + dx;
            o.y = v.y - dy;
            o.z = v.z + at;
        end else begin
            o.x = v.x - dx;
            o.y = v.y + dy;
            o.z = v.z - at;
        end
        return o;
    endfunction

    function automatic t_rot rinit(input logic signed [W-1:0] z);
        t_rot r;
        r.x   = GainInit;
        r.y   = '0;
        r.z   = z;
        r.neg = 1'b0;
        if (z > AngHalfPi) begin
            r.z   = z - AngPi;
            r.neg = 1'b1;
        end else if (z < -AngHalfPi) begin
            r.z   = z + AngPi;
            r.neg = 1'b1;
        end
        return r;
    endfunction

    function automatic t_rot rstep(input t_rot r, input int i);
        t_rot o;
        logic signed [W-1:0] dx;
        logic signed [W-1:0] dy;
        logic signed [W-1:0] at;
        dx = r.y >>> i;
        dy = r.x >>> i;
        at = atan_at(i);
        o  = r;
        if (!r.z[W-1]) begin
            o.x = r.x - dx;
            o.y = r.y + dy;
            o.z = r.z - at;
        end else begin
            o.x = r.x + dx;
            o.y = r.y - dy;
            o.z = r.z + at;
        end
        return o;
    endfunction

    // round half up to Q1.14 and clamp to +-1.0
    function automatic logic signed [15:0] to_q14(input logic signed [W-1:0] v, input logic neg);
        logic signed [W-1:0] n;
        logic signed [W:0]   t;
        logic signed [W-16:0] s;
        logic signed [15:0]  o;
        n = neg ? -v : v;
        t = (W+1)'(n) + (W+1)'(32768);
        s = t[W:16];
        if (s > (W-15)'(16384))       o = 16'sd16384;
        else if (s < -(W-15)'(16384)) o = -16'sd16384;
        else                          o = s[15:0];
        return o;
    endfunction

endpackage

// ===== hdl/svd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svd_in_if / svd_out_if
// Valid/ready channels for the Jacobian input and the decomposition output.
// ----------------------------------------------------------------------------
interface svd_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] j00;
    logic signed [15:0] j10;
    logic signed [15:0] j01;
    logic signed [15:0] j11;
    modport source (output valid, j00, j10, j01, j11, input ready);
    modport sink   (input valid, j00, j10, j01, j11, output ready);
endinterface

interface svd_out_if;
    logic               valid;
    logic               ready;
    logic        [16:0] sigma_major;
    logic signed [16:0] sigma_minor;
    logic signed [15:0] left_cos;
    logic signed [15:0] left_sin;
    logic signed [15:0] right_cos;
    logic signed [15:0] right_sin;
    modport source (output valid, sigma_major, sigma_minor, left_cos, left_sin,
                    right_cos, right_sin, input ready);
    modport sink   (input valid, sigma_major, sigma_minor, left_cos, left_sin,
                    right_cos, right_sin, output ready);
endinterface

// ===== hdl/svd_2x2_closed_form_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svd_2x2_closed_form_unit
// Closed-form SVD of a 2x2 Q4.12 matrix with pipelined CORDIC units.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : one Jacobian (j00, j10, j01, j11) per transfer, valid/ready.
//   o_out : sigma_major, sigma_minor (Q5.12) and cos/sin of the U and V
//           rotation angles (Q1.14), one result per input transfer, in order.
// Pipeline, N = min(CORDIC_STAGES, 24): input stage, N
//   vectoring stages (two CORDICs side by side), gain multiply, angle halving
//   and quadrant fold, N rotation stages, output rounding register.
// Throughput: one matrix per cycle unless stalled; each stage has a valid bit.
// Stall: the whole pipeline holds while the output register carries a result
//   that is not taken; i_in.ready is low only then.
// Reset: synchronous, active low; clears all valid bits, data is left as is.
// ----------------------------------------------------------------------------
module svd_2x2_closed_form_unit
    import svd_pkg::*;
#(
    parameter int CORDIC_STAGES = CordicStagesDef
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    svd_in_if.sink    i_in,
    svd_out_if.source o_out
);

    localparam int NS = (CORDIC_STAGES > AtanTabLen) ? AtanTabLen : CORDIC_STAGES;

    logic en;
    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    // vectoring pipeline: q path (E,H), r path (F,G)
    t_vec        r_vq [0:NS];
    t_vec        r_vr [0:NS];
    logic [NS:0] r_v_valid;

    logic signed [16:0] n_e, n_f, n_g, n_h;
    always_comb begin
        n_e = 17'(i_in.j00) + 17'(i_in.j11);
        n_f = 17'(i_in.j00) - 17'(i_in.j11);
        n_g = 17'(i_in.j10) + 17'(i_in.j01);
        n_h = 17'(i_in.j10) - 17'(i_in.j01);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_valid[0] <= 1'b0;
        end else if (en) begin
            r_v_valid[0] <= i_in.valid;
        end
        if (en) begin
            r_vq[0] <= vinit(n_e, n_h);
            r_vr[0] <= vinit(n_f, n_g);
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_vec
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v_valid[k+1] <= 1'b0;
            end else if (en) begin
                r_v_valid[k+1] <= r_v_valid[k];
            end
            if (en) begin
                r_vq[k+1] <= vstep(r_vq[k], k);
                r_vr[k+1] <= vstep(r_vr[k], k);
            end
        end
    end

    // gain correction; x is non-negative and below 2^32 here
    logic [61:0]         r_mq, r_mr;
    logic signed [W-1:0] r_a2, r_a1;
    logic                r_m_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= r_v_valid[NS];
        end
        if (en) begin
            r_mq <= r_vq[NS].x[31:0] * GainQ30;
            r_mr <= r_vr[NS].x[31:0] * GainQ30;
            r_a2 <= r_vq[NS].zero ? '0 : r_vq[NS].z;
            r_a1 <= r_vr[NS].zero ? '0 : r_vr[NS].z;
        end
    end

    // singular values, half angles, rotation start
    logic signed [W-1:0] q, r, sum_s, dif_s;
    logic signed [W:0]   phi_2, rho_2;
    logic signed [18:0]  smaj_w, smin_w;
    logic        [16:0]  n_smaj;
    logic signed [16:0]  n_smin;

    always_comb begin
        q      = signed'({2'b00, r_mq[61:30]});
        r      = signed'({2'b00, r_mr[61:30]});
        sum_s  = q + r + W'(16384);
        dif_s  = q - r + W'(16384);
        smaj_w = sum_s[W-1:15];
        smin_w = dif_s[W-1:15];
        if (smaj_w < 19'sd0)           n_smaj = '0;
        else if (smaj_w > 19'sd131071) n_smaj = 17'd131071;
        else                           n_smaj = smaj_w[16:0];
        if (smin_w < -19'sd65536)      n_smin = -17'sd65536;
        else if (smin_w > 19'sd65535)  n_smin = 17'sd65535;
        else                           n_smin = smin_w[16:0];
        phi_2  = (W+1)'(r_a2) + (W+1)'(r_a1);
        rho_2  = (W+1)'(r_a2) - (W+1)'(r_a1);
    end

    t_rot        r_rl [0:NS];
    t_rot        r_rr [0:NS];
    logic [16:0]        r_smaj [0:NS];
    logic signed [16:0] r_smin [0:NS];
    logic [NS:0] r_r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid[0] <= 1'b0;
        end else if (en) begin
            r_r_valid[0] <= r_m_valid;
        end
        if (en) begin
            r_rl[0]   <= rinit(phi_2[W:1]);
            r_rr[0]   <= rinit(rho_2[W:1]);
            r_smaj[0] <= n_smaj;
            r_smin[0] <= n_smin;
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_r_valid[k+1] <= 1'b0;
            end else if (en) begin
                r_r_valid[k+1] <= r_r_valid[k];
            end
            if (en) begin
                r_rl[k+1]   <= rstep(r_rl[k], k);
                r_rr[k+1]   <= rstep(r_rr[k], k);
                r_smaj[k+1] <= r_smaj[k];
                r_smin[k+1] <= r_smin[k];
            end
        end
    end

    // output register
    logic               r_out_valid;
    logic        [16:0] r_o_smaj;
    logic signed [16:0] r_o_smin;
    logic signed [15:0] r_lc, r_ls, r_rc, r_rs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_r_valid[NS];
        end
        if (en) begin
            r_o_smaj <= r_smaj[NS];
            r_o_smin <= r_smin[NS];
            r_lc     <= to_q14(r_rl[NS].x, r_rl[NS].neg);
            r_ls     <= to_q14(r_rl[NS].y, r_rl[NS].neg);
            r_rc     <= to_q14(r_rr[NS].x, r_rr[NS].neg);
            r_rs     <= to_q14(r_rr[NS].y, r_rr[NS].neg);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.sigma_major = r_o_smaj;
    assign o_out.sigma_minor = r_o_smin;
    assign o_out.left_cos    = r_lc;
    assign o_out.left_sin    = r_ls;
    assign o_out.right_cos   = r_rc;
    assign o_out.right_sin   = r_rs;

    // major value never below minor value (r is a magnitude)
    a_sigma_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (signed'({1'b0, r_o_smaj}) >= 18'(r_o_smin)))
        else $error("sigma_major below sigma_minor");

    // input back-pressure only comes from a held output
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_out_valid && !o_out.ready))
        else $error("input stalled without output stall");

    // no result straight out of reset
    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !r_out_valid)
        else $error("output valid after reset");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for svd_2x2_closed_form_unit: a directed set of corner matrices,
// then random Jacobians, with random input bursts and output stalls. Every
// result is checked field by field against a bit-accurate CORDIC predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import svd_pkg::*;

    localparam int  Stages    = 16;
    localparam int  NumRandom = 450;
    localparam int  NumDir    = 22;
    localparam real ClkPeriod = 10.0;

    typedef struct packed {
        logic signed [15:0] j00;
        logic signed [15:0] j10;
        logic signed [15:0] j01;
        logic signed [15:0] j11;
    } t_jac;

    typedef struct packed {
        logic        [16:0] sigma_major;
        logic signed [16:0] sigma_minor;
        logic signed [15:0] left_cos;
        logic signed [15:0] left_sin;
        logic signed [15:0] right_cos;
        logic signed [15:0] right_sin;
    } t_svd;

    // atan(2^-i) in binary-angle units, pi = 2^31
    localparam longint AtanLut [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
        64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051};
    localparam longint Gain   = 64'h26DD3B6A;
    localparam longint Pi     = 64'sd2147483648;
    localparam longint HalfPi = 64'sd1073741824;

    class svd_scoreboard;
        t_svd   pending[$];
        int     n_err;
        int     n_checked;

        function automatic longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function automatic void vector_mode(longint x0, longint y0,
                                            output longint mag, output longint ang);
            longint x, y, z, dx, dy;
            int n;
            n = Stages > 24 ? 24 : Stages;
            mag = 0;
            ang = 0;
            if (x0 == 0 && y0 == 0) return;
            x = x0 * 16384;
            y = y0 * 16384;
            z = 0;
            if (x < 0) begin
                z = (y >= 0) ? Pi : -Pi;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < n; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx; y -= dy; z += AtanLut[i];
                end else begin
                    x -= dx; y += dy; z -= AtanLut[i];
                end
            end
            mag = (x * Gain) >>> 30;
            ang = z;
        endfunction

        function automatic logic signed [15:0] q14(longint v);
            return 16'(clip((v + 32768) >>> 16, -16384, 16384));
        endfunction

        function automatic void rotate(longint z, output logic signed [15:0] c,
                                       output logic signed [15:0] s);
            longint x, y, dx, dy;
            bit flip;
            int n;
            n = Stages > 24 ? 24 : Stages;
            x = Gain;
            y = 0;
            flip = 0;
            if (z > HalfPi) begin
                z -= Pi; flip = 1;
            end else if (z < -HalfPi) begin
                z += Pi; flip = 1;
            end
            for (int i = 0; i < n; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= AtanLut[i];
                end else begin
                    x += dx; y -= dy; z += AtanLut[i];
                end
            end
            if (flip) begin
                x = -x; y = -y;
            end
            c = q14(x);
            s = q14(y);
        endfunction

        function void note_input(t_jac j);
            longint e, f, g, h, q, r, a1, a2, phi, rho;
            t_svd   o;
            e = longint'(j.j00) + longint'(j.j11);
            f = longint'(j.j00) - longint'(j.j11);
            g = longint'(j.j10) + longint'(j.j01);
            h = longint'(j.j10) - longint'(j.j01);
            vector_mode(e, h, q, a2);
            vector_mode(f, g, r, a1);
            phi = (a2 + a1) >>> 1;
            rho = (a2 - a1) >>> 1;
            o.sigma_major = 17'(clip((q + r + 16384) >>> 15, 0, 131071));
            o.sigma_minor = 17'(clip((q - r + 16384) >>> 15, -65536, 65535));
            rotate(phi, o.left_cos, o.left_sin);
            rotate(rho, o.right_cos, o.right_sin);
            pending = {pending, o};
        endfunction

        function void check_result(t_svd got);
            t_svd want;
            n_checked++;
            if (pending.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("ERROR: result with nothing pending: %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                n_err++;
                if (n_err <= 10) $display("ERROR: result %0d exp %p got %p",
                                          n_checked, want, got);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    svd_in_if  jac_if();
    svd_out_if res_if();
    svd_scoreboard sb = new();
    int n_sent;

    always #(ClkPeriod / 2) i_clk = ~i_clk;

    svd_2x2_closed_form_unit #(.CORDIC_STAGES(Stages)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (jac_if.sink),
        .o_out   (res_if.source)
    );

    // sender: one transfer, then a gap or not, chosen by the caller
    task automatic send_jac(t_jac j);
        jac_if.valid <= 1;
        jac_if.j00 <= j.j00;
        jac_if.j10 <= j.j10;
        jac_if.j01 <= j.j01;
        jac_if.j11 <= j.j11;
        do @(posedge i_clk); while (!jac_if.ready);
        sb.note_input(j);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic idle_gap(int n);
        jac_if.valid <= 0;
        repeat (n) @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] rnd16();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'($urandom_range(0, 16)) - 16'sd8;
            4: return 16'($urandom_range(0, 8192)) - 16'sd4096;
            default: return 16'($urandom());
        endcase
    endfunction

    // receiver: stall pattern in phases, including long stretches with none
    initial begin
        int mode;
        res_if.ready = 0;
        @(posedge i_rst_n);
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(5, 60)) begin
                @(negedge i_clk);
                case (mode)
                    0: res_if.ready <= 1;
                    1: res_if.ready <= ($urandom_range(0, 3) != 0);
                    2: res_if.ready <= ($urandom_range(0, 3) == 0);
                    default: res_if.ready <= ~res_if.ready;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            sb.check_result('{res_if.sigma_major, res_if.sigma_minor, res_if.left_cos,
                              res_if.left_sin, res_if.right_cos, res_if.right_sin});
        end
    end

    initial begin
        #(ClkPeriod * 400000);
        $display("timeout");
        $display("simulation failed");
        $finish;
    end

    initial begin
        t_jac dir [NumDir];
        t_jac j;
        int left;
        jac_if.valid = 0;
        jac_if.j00 = 0;
        jac_if.j10 = 0;
        jac_if.j01 = 0;
        jac_if.j11 = 0;
        n_sent = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // directed: zero matrix, identity, rotations, reflections, extremes
        dir = '{
            '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
            '{16'sh1000, 16'sh0000, 16'sh0000, 16'sh1000},
            '{16'shF000, 16'sh0000, 16'sh0000, 16'shF000},
            '{16'sh1000, 16'sh0000, 16'sh0000, 16'shF000},
            '{16'sh0000, 16'sh1000, 16'shF000, 16'sh0000},
            '{16'sh0000, 16'shF000, 16'sh1000, 16'sh0000},
            '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
            '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
            '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000},
            '{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000},
            '{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF},
            '{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000},
            '{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF},
            '{16'sh8000, 16'sh0000, 16'sh0000, 16'sh7FFF},
            '{16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000},
            '{16'shFFFF, 16'sh0000, 16'sh0000, 16'sh0000},
            '{16'sh0000, 16'sh0000, 16'sh0001, 16'sh0000},
            '{16'sh0000, 16'shFFFF, 16'sh0000, 16'sh0000},
            '{16'shFFFF, 16'sh0000, 16'sh0000, 16'sh0001},
            '{16'sh1000, 16'sh1000, 16'sh1000, 16'sh1000},
            '{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA},
            '{16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555}};
        foreach (dir[k]) send_jac(dir[k]);
        idle_gap(3);

        left = NumRandom;
        while (left > 0) begin
            repeat ($urandom_range(1, 40)) begin
                if (left > 0) begin
                    j = '{rnd16(), rnd16(), rnd16(), rnd16()};
                    send_jac(j);
                    left--;
                end
            end
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
        end
        jac_if.valid <= 0;

        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (2 * Stages + 20) @(negedge i_clk);

        $display("sent %0d matrices (%0d directed), checked %0d decompositions",
                 n_sent, NumDir, sb.n_checked);
        $display("mismatches: %0d", sb.n_err);
        if (sb.n_err == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
